### design/mmt_pkg.sv
// Shared constants, table of keywords/operators and types of the tokenizer.
// No dependencies; used by every module of the block.
package mmt_pkg;

    localparam int DEPTH       = 8;                  // lookahead window bytes
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int LONGEST     = 8;                  // longest table entry
    localparam int LEN_W       = $clog2(LONGEST + 1);
    localparam int ENTRY_COUNT = 36;
    localparam int KIND_W      = 6;

    localparam logic [KIND_W-1:0] KIND_NAME   = 6'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd1;
    localparam logic [KIND_W-1:0] KIND_STRING = 6'd2;
    localparam int                KIND_TABLE  = 3;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NAME   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_STRING = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // entry text left aligned: character i at bits [63-8*i -: 8]
    localparam logic [63:0] ENTRY_TEXT [ENTRY_COUNT] = '{
        {"function"}, {"var", 40'd0},
        {"=", 56'd0}, {";", 56'd0}, {"(", 56'd0}, {")", 56'd0},
        {"{", 56'd0}, {"}", 56'd0}, {"[", 56'd0}, {"]", 56'd0},
        {"+", 56'd0}, {"-", 56'd0}, {"*", 56'd0}, {"/", 56'd0},
        {"%", 56'd0}, {".", 56'd0}, {",", 56'd0},
        {"+=", 48'd0}, {"-=", 48'd0}, {"*=", 48'd0}, {"%=", 48'd0},
        {"::", 48'd0}, {"==", 48'd0},
        {"<", 56'd0}, {">", 56'd0},
        {"<=", 48'd0}, {">=", 48'd0}, {"!=", 48'd0}, {"&&", 48'd0},
        {"||", 48'd0},
        {"!", 56'd0}, {"&", 56'd0}, {"|", 56'd0}, {"^", 56'd0},
        {"<<", 48'd0}, {">>", 48'd0}
    };

    localparam logic [LEN_W-1:0] ENTRY_LEN [ENTRY_COUNT] = '{
        4'd8, 4'd3,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2
    };

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
    } match_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        byte_t             data;
        logic              byte_valid;
        logic              first;
        logic              last;
        logic              unterm;
    } result_t;

endpackage

### design/maximal_munch_tokenizer_top.sv
// Top level of the maximal-munch tokenizer: lookahead window, scan engine.
// Depends on mmt_pkg, mmt_match, mmt_outreg.
//
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------
//  s_      | in        | s_valid s_ready s_text_byte s_end_of_text
//  m_      | out       | m_valid m_ready m_token_kind m_out_byte
//          |           | m_byte_valid m_token_first m_token_last
//          |           | m_unterminated_string
//
// The engine takes one step per cycle, each step giving at most one result
// word; a table entry of n characters takes n steps. Steady state is one
// byte per cycle while each byte gives about one word: a byte is taken in
// the cycle the head step drops a byte from a full window. A name or number
// end costs one extra step. End of text flushes the window, one step per
// byte plus one closing step, with input held off. Reset (aresetn low,
// synchronous) empties the window and returns to between-token scanning.
// A stall on m_ready freezes the engine; input is still taken while the
// window has room.
module maximal_munch_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_token_kind,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_token_first,
    output logic       m_token_last,
    output logic       m_unterminated_string
);

    localparam int DEPTH = mmt_pkg::DEPTH;
    localparam int CNT_W = mmt_pkg::CNT_W;
    localparam int LEN_W = mmt_pkg::LEN_W;

    // window and scan state
    mmt_pkg::byte_t             win_reg [DEPTH];
    mmt_pkg::byte_t             win_next [DEPTH];
    logic [CNT_W-1:0]           cnt_reg;
    logic [1:0]                 mode_reg,  mode_next;
    logic                       open_reg,  open_next;
    mmt_pkg::byte_t             held_reg,  held_next;
    logic                       hfirst_reg, hfirst_next;
    logic [LEN_W-1:0]           left_reg,  left_next;   // entry chars still to send
    logic [5:0]                 ekind_reg, ekind_next;
    logic                       flush_reg, flush_next;

    mmt_pkg::match_t            match;
    mmt_pkg::result_t           res, m_res;
    logic                       emit, drop, fire, active, free, accept;
    logic                       full, nonempty, blank, digit, quote, goes_on;
    mmt_pkg::byte_t             c;
    logic [CNT_W-1:0]           wr_idx;
    mmt_pkg::result_t           held_res;

    mmt_match u_match (
        .win   (win_reg),
        .cnt   (cnt_reg),
        .match (match)
    );

    assign c        = win_reg[0];
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign blank    = (c == mmt_pkg::CH_SPACE) || (c == mmt_pkg::CH_TAB);
    assign digit    = (c >= mmt_pkg::CH_ZERO) && (c <= mmt_pkg::CH_NINE);
    assign quote    = (c == mmt_pkg::CH_QUOTE);

    // a step is due while entry chars remain, the window is full, or flushing; it runs when the output is free
    assign active = (left_reg != '0) || full || flush_reg;
    assign fire   = active && free;

    // held character of a name, number or string
    always_comb begin
        held_res.kind       = {4'd0, mode_reg - 2'd1};
        held_res.data       = held_reg;
        held_res.byte_valid = 1'b1;
        held_res.first      = hfirst_reg;
        held_res.last       = 1'b0;
        held_res.unterm     = 1'b0;
    end

    always_comb begin
        emit        = 1'b0;
        drop        = 1'b0;
        res         = held_res;
        mode_next   = mode_reg;
        open_next   = open_reg;
        held_next   = held_reg;
        hfirst_next = hfirst_reg;
        left_next   = left_reg;
        ekind_next  = ekind_reg;
        flush_next  = flush_reg;
        goes_on     = (mode_reg == mmt_pkg::MODE_NUMBER) ? (digit || c == mmt_pkg::CH_DOT)
                                                         : (!blank && !match.hit);
        if (left_reg != '0) begin
            // rest of a multi-character table entry
            emit           = 1'b1;
            drop           = 1'b1;
            res.kind       = ekind_reg;
            res.data       = c;
            res.first      = 1'b0;
            res.last       = (left_reg == LEN_W'(1));
            left_next      = left_reg - LEN_W'(1);
        end else if (full || (flush_reg && nonempty)) begin
            unique case (mode_reg)
                mmt_pkg::MODE_IDLE: begin
                    if (match.hit) begin
                        emit       = 1'b1;
                        drop       = 1'b1;
                        res.kind   = match.kind;
                        res.data   = c;
                        res.first  = 1'b1;
                        res.last   = (match.len == LEN_W'(1));
                        left_next  = match.len - LEN_W'(1);
                        ekind_next = match.kind;
                    end else if (blank) begin
                        drop = 1'b1;
                    end else if (quote) begin
                        drop      = 1'b1;
                        mode_next = mmt_pkg::MODE_STRING;
                        open_next = 1'b0;
                    end else begin
                        drop        = 1'b1;
                        mode_next   = digit ? mmt_pkg::MODE_NUMBER : mmt_pkg::MODE_NAME;
                        held_next   = c;
                        hfirst_next = 1'b1;
                        open_next   = 1'b1;
                    end
                end
                mmt_pkg::MODE_STRING: begin
                    drop = 1'b1;
                    if (quote) begin
                        emit = 1'b1;
                        res.last = 1'b1;
                        if (!open_reg) begin
                            res.kind       = mmt_pkg::KIND_STRING;
                            res.data       = '0;
                            res.byte_valid = 1'b0;
                            res.first      = 1'b1;
                        end
                        mode_next = mmt_pkg::MODE_IDLE;
                        open_next = 1'b0;
                    end else begin
                        emit        = open_reg;
                        held_next   = c;
                        hfirst_next = !open_reg;
                        open_next   = 1'b1;
                    end
                end
                default: begin
                    // name or number
                    emit = 1'b1;
                    if (goes_on) begin
                        drop        = 1'b1;
                        held_next   = c;
                        hfirst_next = 1'b0;
                    end else begin
                        res.last  = 1'b1;
                        mode_next = mmt_pkg::MODE_IDLE;
                        open_next = 1'b0;
                    end
                end
            endcase
        end else begin
            // closing step of end of text, window empty
            res.last = 1'b1;
            if (mode_reg == mmt_pkg::MODE_STRING) begin
                emit       = 1'b1;
                res.unterm = 1'b1;
                if (!open_reg) begin
                    res.kind       = mmt_pkg::KIND_STRING;
                    res.data       = '0;
                    res.byte_valid = 1'b0;
                    res.first      = 1'b1;
                end
            end else begin
                emit = (mode_reg != mmt_pkg::MODE_IDLE) && open_reg;
            end
            mode_next  = mmt_pkg::MODE_IDLE;
            open_next  = 1'b0;
            flush_next = 1'b0;
        end
    end

    // a byte enters, outside a flush, when the window has room or the head step frees a slot
    assign s_ready = !flush_reg && (!full || (fire && drop));
    assign accept  = s_valid && s_ready;
    assign wr_idx  = cnt_reg - CNT_W'(fire && drop);

    // shift on a head drop, then write the incoming byte behind the tail
    always_comb begin
        win_next = win_reg;
        if (fire && drop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
        end
        if (accept) begin
            win_next[wr_idx[mmt_pkg::PTR_W-1:0]] = s_text_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            mode_reg  <= mmt_pkg::MODE_IDLE;
            open_reg  <= 1'b0;
            left_reg  <= '0;
            flush_reg <= 1'b0;
        end else begin
            cnt_reg <= wr_idx + CNT_W'(accept);
            if (fire) begin
                mode_reg  <= mode_next;
                open_reg  <= open_next;
                left_reg  <= left_next;
                flush_reg <= flush_next;
            end
            if (accept && s_end_of_text) begin
                flush_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            held_reg   <= held_next;
            hfirst_reg <= hfirst_next;
            ekind_reg  <= ekind_next;
        end
        win_reg <= win_next;
    end

    mmt_outreg u_outreg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && emit),
        .res     (res),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_token_kind          = m_res.kind;
    assign m_out_byte            = m_res.data;
    assign m_byte_valid          = m_res.byte_valid;
    assign m_token_first         = m_res.first;
    assign m_token_last          = m_res.last;
    assign m_unterminated_string = m_res.unterm;

endmodule

### design/mmt_match.sv
// Longest-match lookup of the keyword/operator table at the window head.
// Depends on mmt_pkg.
module mmt_match (
    input  mmt_pkg::byte_t                win [mmt_pkg::DEPTH],
    input  logic [mmt_pkg::CNT_W-1:0]     cnt,
    output mmt_pkg::match_t               match
);

    logic [mmt_pkg::ENTRY_COUNT-1:0] hit;
    logic [mmt_pkg::LEN_W-1:0]       max_len;
    logic [mmt_pkg::KIND_W-1:0]      kind;

    always_comb begin
        for (int e = 0; e < mmt_pkg::ENTRY_COUNT; e++) begin
            hit[e] = ({{(mmt_pkg::LEN_W > mmt_pkg::CNT_W ? mmt_pkg::LEN_W - mmt_pkg::CNT_W
                       : 0){1'b0}}, cnt} >= mmt_pkg::ENTRY_LEN[e]);
            for (int i = 0; i < mmt_pkg::LONGEST; i++) begin
                if (i < int'(mmt_pkg::ENTRY_LEN[e])) begin
                    if (i >= mmt_pkg::DEPTH) begin
                        hit[e] = 1'b0;
                    end else if (win[i % mmt_pkg::DEPTH] !=
                                 mmt_pkg::ENTRY_TEXT[e][63-8*i -: 8]) begin
                        hit[e] = 1'b0;
                    end
                end
            end
        end
    end

    // longest hit wins; texts of equal length are distinct
    always_comb begin
        max_len = '0;
        for (int e = 0; e < mmt_pkg::ENTRY_COUNT; e++) begin
            if (hit[e] && mmt_pkg::ENTRY_LEN[e] > max_len) begin
                max_len = mmt_pkg::ENTRY_LEN[e];
            end
        end
        kind = '0;
        for (int e = 0; e < mmt_pkg::ENTRY_COUNT; e++) begin
            if (hit[e] && mmt_pkg::ENTRY_LEN[e] == max_len) begin
                kind = kind | mmt_pkg::KIND_W'(e + mmt_pkg::KIND_TABLE);
            end
        end
    end

    assign match.hit  = |hit;
    assign match.kind = kind;
    assign match.len  = max_len;

endmodule

### design/mmt_outreg.sv
// Result output register with valid/ready handshake.
// Depends on mmt_pkg.
module mmt_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mmt_pkg::result_t  res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output mmt_pkg::result_t  m_res
);

    logic             valid_reg;
    mmt_pkg::result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

### design/mmt_checker.sv
// Port-level checks of the tokenizer result stream, bound to the top level.
// Depends on mmt_pkg and maximal_munch_tokenizer_top.
module mmt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_token_kind,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_token_first,
    input logic       m_token_last,
    input logic       m_unterminated_string
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_out_byte))
        else $error("result word changed under stall");

    a_empty_string: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_token_kind == mmt_pkg::KIND_STRING
                                     && m_token_first && m_token_last && m_out_byte == 8'd0)
        else $error("malformed empty string word");

    a_unterminated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unterminated_string |-> m_token_kind == mmt_pkg::KIND_STRING
                                             && m_token_last)
        else $error("unterminated flag off a closing string word");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind < 6'(mmt_pkg::KIND_TABLE + mmt_pkg::ENTRY_COUNT))
        else $error("token kind out of range");

endmodule

bind maximal_munch_tokenizer_top mmt_checker u_mmt_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_token_kind          (m_token_kind),
    .m_out_byte            (m_out_byte),
    .m_byte_valid          (m_byte_valid),
    .m_token_first         (m_token_first),
    .m_token_last          (m_token_last),
    .m_unterminated_string (m_unterminated_string)
);
